// ===== rtl/sample_percentile_stats_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sample percentile statistics unit
// Shared property forms used by the RTL module that carries assertions.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_PERCENTILE_STATS_UNIT_DEFINES_SVH
`define SAMPLE_PERCENTILE_STATS_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define SPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle property failed");

`endif

// ===== rtl/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// Types, constants and codes shared by the sample percentile statistics unit.
// ----------------------------------------------------------------------------
package sps_pkg;

	localparam int DEPTH_DEF = 256;
	localparam int WORD_W    = 32;
	localparam int PCT_W     = 7;
	localparam int CNT_OUT_W = 9;
	localparam int PROD_W    = WORD_W + PCT_W;
	localparam int CFG_IDX_W = 1;

	localparam logic [PCT_W-1:0] PCT_FULL         = 7'd100;
	localparam logic [PCT_W-1:0] PCT_RESET_FIRST  = 7'd95;
	localparam logic [PCT_W-1:0] PCT_RESET_SECOND = 7'd99;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND = 1'b1;

	localparam logic ACT_ADD    = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	typedef struct packed {
		logic              action;
		logic [WORD_W-1:0] sample_value;
	} item_t;

	typedef struct packed {
		logic [WORD_W-1:0]    mean_value;
		logic [WORD_W-1:0]    first_pct_value;
		logic [WORD_W-1:0]    second_pct_value;
		logic [CNT_OUT_W-1:0] sample_count;
		logic                 set_valid;
		logic                 overflowed;
	} result_t;

	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEAN,
		ST_LO1,
		ST_LO2,
		ST_SCAN,
		ST_INT1,
		ST_INT2,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/sample_percentile_stats_unit.sv =====
// ----------------------------------------------------------------------------
// sample_percentile_stats_unit
// Sample store with sorted insertion, mean and two interpolated percentiles.
// ----------------------------------------------------------------------------
// An add beat is taken and busy stays low, so adds may follow back to back;
// while fewer than DEPTH samples are held, the sample is placed in order in
// a chain of DEPTH cells. A finish beat raises busy while the unit takes the
// mean of the n held samples on a one-bit-per-cycle divider over the running
// sum, SW = 32 + clog2(DEPTH + 1) bits wide; finds the two ranks on a
// pipelined divide-by-hundred; shifts the sorted chain out past the head cell;
// interpolates the two percentiles on the divide-by-hundred; and reports. An
// empty finish raises busy for one cycle. The result is on result from the
// cycle after busy falls, in which done is high for a single cycle; the
// receiver cannot stall it, so it must take it then.
// ----------------------------------------------------------------------------
`include "sample_percentile_stats_unit_defines.svh"

module sample_percentile_stats_unit #(
	parameter int DEPTH = sps_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  sps_pkg::item_t                    item,
	input  logic                              cfg_we,
	input  logic [sps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sps_pkg::PCT_W-1:0]         cfg_data,
	output logic                              done,
	output sps_pkg::result_t                  result
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int SUMW = sps_pkg::WORD_W + CW;
	localparam int DW   = SUMW;
	localparam int VW   = CW;
	localparam int QW   = sps_pkg::PCT_W + CW;
	localparam int LW   = 20;
	localparam int HW   = sps_pkg::PROD_W - LW;
	localparam int RW   = LW + sps_pkg::PCT_W;
	localparam int RS   = 34;
	localparam int PW   = RW + 28;
	localparam logic [27:0] RECIP = 28'd171798692;

	sps_pkg::state_t state_q, state_d;

	logic [sps_pkg::PCT_W-1:0]  p1_q, p2_q, p1c, p2c;
	logic [CW-1:0]              cnt_q, k_q, lo1_q, lo2_q;
	logic [SUMW-1:0]            sum_q;
	logic                       drop_q, lch_q, done_q;
	logic [sps_pkg::PCT_W-1:0]  f1_q, f2_q;
	logic [sps_pkg::WORD_W-1:0] mean_q, a1_q, b1_q, a2_q, b2_q, v1_q, v2_q;
	sps_pkg::result_t           res_q;

	logic                       accept, add_ok;
	sps_pkg::cell_ctl_t         ctl;
	logic                       dv_start, dv_done;
	logic [DW-1:0]              dv_dvd, dv_quo;
	logic [VW-1:0]              dv_dvs;
	logic [QW-1:0]              q1, q2;
	logic [sps_pkg::PROD_W-1:0] prod1, prod2;

	logic                       hd_start, st_done;
	logic [sps_pkg::PROD_W-1:0] hd_dvd, hd_quo, hx_q;
	logic [sps_pkg::PCT_W-1:0]  hd_rem;
	logic [HW-1:0]              hqh_s1;
	logic [sps_pkg::PCT_W-1:0]  hrh_s2, hry_s4;
	logic [LW-1:0]              hqy_s3;
	logic [RW-1:0]              hy;
	logic [4:0]                 hv_q;

	logic [sps_pkg::WORD_W-1:0] vals [DEPTH];
	logic                       gts  [DEPTH];

	function automatic logic [RW-1:0] quot100(logic [RW-1:0] x);
		logic [PW-1:0] p;
		p = PW'(x) * PW'(RECIP);
		return RW'(p[PW-1:RS]);
	endfunction

	assign busy   = (state_q != sps_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign add_ok = accept && (item.action == sps_pkg::ACT_ADD) && (cnt_q < CW'(DEPTH));

	assign p1c   = (p1_q > sps_pkg::PCT_FULL) ? sps_pkg::PCT_FULL : p1_q;
	assign p2c   = (p2_q > sps_pkg::PCT_FULL) ? sps_pkg::PCT_FULL : p2_q;
	assign q1    = QW'(p1c) * QW'(cnt_q - 1'b1);
	assign q2    = QW'(p2c) * QW'(cnt_q - 1'b1);
	assign prod1 = (f1_q == '0) ? '0 :
		sps_pkg::PROD_W'(b1_q - a1_q) * sps_pkg::PROD_W'(f1_q);
	assign prod2 = (f2_q == '0) ? '0 :
		sps_pkg::PROD_W'(b2_q - a2_q) * sps_pkg::PROD_W'(f2_q);

	assign hy      = {hrh_s2, hx_q[LW-1:0]};
	assign hd_quo  = {hqh_s1, hqy_s3};
	assign hd_rem  = hry_s4;
	assign st_done = (state_q == sps_pkg::ST_MEAN) ? dv_done : hv_q[4];

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [sps_pkg::WORD_W-1:0] pv, nv;
			logic                       pg;
			if (gi == 0) begin : g_head
				assign pv = '0;
				assign pg = 1'b0;
			end else begin : g_body
				assign pv = vals[gi-1];
				assign pg = gts[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_tail
				assign nv = '0;
			end else begin : g_link
				assign nv = vals[gi+1];
			end
			sps_cell #(
				.CNT_W (CW),
				.IDX   (gi)
			) u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.cnt      (cnt_q),
				.new_val  (item.sample_value),
				.prev_val (pv),
				.prev_gt  (pg),
				.next_val (nv),
				.val      (vals[gi]),
				.gt       (gts[gi])
			);
		end
	endgenerate

	sps_div #(
		.DW (DW),
		.VW (VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (dv_dvd),
		.divisor  (dv_dvs),
		.done     (dv_done),
		.quo      (dv_quo)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sps_pkg::ST_IDLE: begin
				if (accept && (item.action == sps_pkg::ACT_FINISH)) begin
					state_d = (cnt_q == '0) ? sps_pkg::ST_DONE : sps_pkg::ST_MEAN;
				end
			end
			sps_pkg::ST_MEAN: if (lch_q && st_done) state_d = sps_pkg::ST_LO1;
			sps_pkg::ST_LO1:  if (lch_q && st_done) state_d = sps_pkg::ST_LO2;
			sps_pkg::ST_LO2:  if (lch_q && st_done) state_d = sps_pkg::ST_SCAN;
			sps_pkg::ST_SCAN: if (k_q == cnt_q - 1'b1) state_d = sps_pkg::ST_INT1;
			sps_pkg::ST_INT1: if (lch_q && st_done) state_d = sps_pkg::ST_INT2;
			sps_pkg::ST_INT2: if (lch_q && st_done) state_d = sps_pkg::ST_DONE;
			sps_pkg::ST_DONE: state_d = sps_pkg::ST_IDLE;
			default:          state_d = sps_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.insert = add_ok;
		ctl.shift  = (state_q == sps_pkg::ST_SCAN);
		dv_start   = 1'b0;
		dv_dvd     = '0;
		dv_dvs     = '0;
		hd_start   = 1'b0;
		hd_dvd     = '0;
		unique case (state_q)
			sps_pkg::ST_MEAN: begin
				dv_start = !lch_q;
				dv_dvd   = DW'(sum_q);
				dv_dvs   = VW'(cnt_q);
			end
			sps_pkg::ST_LO1: begin
				hd_start = !lch_q;
				hd_dvd   = sps_pkg::PROD_W'(q1);
			end
			sps_pkg::ST_LO2: begin
				hd_start = !lch_q;
				hd_dvd   = sps_pkg::PROD_W'(q2);
			end
			sps_pkg::ST_INT1: begin
				hd_start = !lch_q;
				hd_dvd   = prod1;
			end
			sps_pkg::ST_INT2: begin
				hd_start = !lch_q;
				hd_dvd   = prod2;
			end
			default: begin
				dv_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sps_pkg::ST_IDLE;
			p1_q    <= sps_pkg::PCT_RESET_FIRST;
			p2_q    <= sps_pkg::PCT_RESET_SECOND;
			cnt_q   <= '0;
			sum_q   <= '0;
			drop_q  <= 1'b0;
			lch_q   <= 1'b0;
			done_q  <= 1'b0;
			k_q     <= '0;
			hv_q    <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == sps_pkg::ST_DONE);
			hv_q    <= {hv_q[3:0], hd_start};
			if (cfg_we) begin
				unique case (cfg_index)
					sps_pkg::CFG_FIRST:  p1_q <= cfg_data;
					sps_pkg::CFG_SECOND: p2_q <= cfg_data;
					default:             p1_q <= p1_q;
				endcase
			end
			if (state_d != state_q) begin
				lch_q <= 1'b0;
			end else if (dv_start || hd_start) begin
				lch_q <= 1'b1;
			end
			if (state_q == sps_pkg::ST_SCAN) begin
				k_q <= k_q + 1'b1;
			end else begin
				k_q <= '0;
			end
			if (add_ok) begin
				cnt_q <= cnt_q + 1'b1;
				sum_q <= sum_q + SUMW'(item.sample_value);
			end else if (accept && (item.action == sps_pkg::ACT_ADD)) begin
				drop_q <= 1'b1;
			end
			if (state_q == sps_pkg::ST_DONE) begin
				cnt_q  <= '0;
				sum_q  <= '0;
				drop_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hd_start) begin
			hx_q <= hd_dvd;
		end
		hqh_s1 <= HW'(quot100(RW'(hx_q[sps_pkg::PROD_W-1:LW])));
		hrh_s2 <= sps_pkg::PCT_W'(hx_q[sps_pkg::PROD_W-1:LW] -
			hqh_s1 * HW'(sps_pkg::PCT_FULL));
		hqy_s3 <= LW'(quot100(hy));
		hry_s4 <= sps_pkg::PCT_W'(hy - RW'(hqy_s3) * RW'(sps_pkg::PCT_FULL));
	end

	always_ff @(posedge clk) begin
		if (lch_q && st_done) begin
			case (state_q)
				sps_pkg::ST_MEAN: mean_q <= dv_quo[sps_pkg::WORD_W-1:0];
				sps_pkg::ST_LO1: begin
					lo1_q <= hd_quo[CW-1:0];
					f1_q  <= hd_rem;
				end
				sps_pkg::ST_LO2: begin
					lo2_q <= hd_quo[CW-1:0];
					f2_q  <= hd_rem;
				end
				sps_pkg::ST_INT1: v1_q <= a1_q + hd_quo[sps_pkg::WORD_W-1:0];
				sps_pkg::ST_INT2: v2_q <= a2_q + hd_quo[sps_pkg::WORD_W-1:0];
				default:          mean_q <= mean_q;
			endcase
		end
		if (state_q == sps_pkg::ST_SCAN) begin
			if (k_q == lo1_q)        a1_q <= vals[0];
			if (k_q == lo1_q + 1'b1) b1_q <= vals[0];
			if (k_q == lo2_q)        a2_q <= vals[0];
			if (k_q == lo2_q + 1'b1) b2_q <= vals[0];
		end
		if (state_q == sps_pkg::ST_DONE) begin
			if (cnt_q == '0) begin
				res_q <= '0;
			end else begin
				res_q.mean_value       <= mean_q;
				res_q.first_pct_value  <= v1_q;
				res_q.second_pct_value <= v2_q;
				res_q.sample_count     <= sps_pkg::CNT_OUT_W'(cnt_q);
				res_q.set_valid        <= 1'b1;
				res_q.overflowed       <= drop_q;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

	`SPS_ASSERT_NEXT(a_done_after_report, state_q == sps_pkg::ST_DONE, done)
	`SPS_ASSERT_NEXT(a_done_one_cycle, done, !done)
	`SPS_ASSERT_NEXT(a_finish_busy, accept && (item.action == sps_pkg::ACT_FINISH), busy)
	`SPS_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= CW'(DEPTH))

endmodule

// ===== rtl/sps_cell.sv =====
// ----------------------------------------------------------------------------
// sps_cell
// One slot of the sorted sample chain: takes part in ordered insertion and
// shifts toward the head of the chain while the set is read out.
// ----------------------------------------------------------------------------
module sps_cell #(
	parameter int CNT_W = 9,
	parameter int IDX   = 0
) (
	input  logic                          clk,
	input  sps_pkg::cell_ctl_t            ctl,
	input  logic [CNT_W-1:0]              cnt,
	input  logic [sps_pkg::WORD_W-1:0]    new_val,
	input  logic [sps_pkg::WORD_W-1:0]    prev_val,
	input  logic                          prev_gt,
	input  logic [sps_pkg::WORD_W-1:0]    next_val,
	output logic [sps_pkg::WORD_W-1:0]    val,
	output logic                          gt
);

	logic [sps_pkg::WORD_W-1:0] val_q;

	assign gt  = (CNT_W'(IDX) >= cnt) || (new_val < val_q);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= next_val;
		end else if (ctl.insert) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (gt) begin
				val_q <= new_val;
			end
		end
	end

endmodule

// ===== rtl/sps_div.sv =====
// ----------------------------------------------------------------------------
// sps_div
// Restoring divider, one quotient bit per cycle, quotient out.
// ----------------------------------------------------------------------------
module sps_div #(
	parameter int DW = 40,
	parameter int VW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quo
);

	localparam int CTW = $clog2(DW);

	logic [CTW-1:0] cnt_q;
	logic           run_q;
	logic           done_q;
	logic [DW-1:0]  quo_q;
	logic [VW-1:0]  rem_q;
	logic [VW-1:0]  dvs_q;
	logic [VW:0]    part;
	logic [VW:0]    trial;

	assign part  = {rem_q, quo_q[DW-1]};
	assign trial = part - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CTW'(DW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!trial[VW]) begin
				rem_q <= trial[VW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= part[VW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
